// ===== hdl/skm_pkg.sv =====
// Shared types and constants for the streaming key name matcher.
// No dependencies; imported by skm_ctrl, skm_dp and the top level.
`default_nettype none

package skm_pkg;

  localparam int NUM_FIELDS   = 8;
  localparam int MAX_NAME_LEN = 16;
  localparam int FIELD_W      = 3;
  localparam int POS_W        = 4;
  localparam int LEN_W        = 5;
  localparam int CHAR_W       = 8;
  localparam int ADDR_W       = FIELD_W + POS_W;
  localparam int MEM_DEPTH    = NUM_FIELDS * MAX_NAME_LEN;

  localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd58;
  localparam logic [LEN_W-1:0]  LEN_MAX     = LEN_W'(MAX_NAME_LEN);
  localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);

  typedef enum logic [1:0] {
    REQ_WRITE_CHAR = 2'd0,
    REQ_SET_LEN    = 2'd1,
    REQ_BEGIN_KEY  = 2'd2,
    REQ_KEY_CHAR   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    OUT_MATCHING = 2'd0,
    OUT_MATCHED  = 2'd1,
    OUT_ALLFAIL  = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_SCAN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic prime;
    logic scan;
    logic finish;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic decided;
    logic hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/streaming_key_name_matcher_unit.sv =====
// Top level of the streaming key name matcher: stream ports, the register
// port and the delimiter register. Depends on skm_pkg, skm_ctrl and skm_dp.
//
//   Channel   Direction  Handshake              Contents
//   in_       slave      in_tvalid/in_tready    one request: load, new key or key char
//   out_      master     out_tvalid/out_tready  one result per request
//   cfg_      APB slave  psel/penable/pready    delimiter_char at byte address 0
//
// Loads and begin-key requests go from acceptance straight to the result step.
// A key character passes through acceptance, a step that primes the name memory
// read, a scan that checks the fields one per cycle through the single read port
// of the name memory, a step that advances the cursor and a step that hands the
// result to the output register; a match stops the scan at the winning field and
// skips the cursor step. A key character that arrives after the key is decided goes straight to the result step.
// Reset is synchronous and active low; the name memory is not cleared.
// The result sits in an output register, so a stalled out_ channel holds only
// the final step of a request; in_tready is high whenever the controller idles.
`default_nettype none

module streaming_key_name_matcher_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // [2:0] field_index, [6:3] char_pos, [14:7] char_value, [19:15] name_length
  input  wire  [23:0] in_tdata,
  // [1:0] req_type
  input  wire  [1:0]  in_tuser,
  output logic        out_tvalid,
  input  wire         out_tready,
  // [1:0] match_state, [4:2] matched_field
  output logic [7:0]  out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import skm_pkg::*;

  logic [CHAR_W-1:0]  delim_r;
  logic               cfg_wr;
  req_t               in_req;
  ctrl_cmd_t          cmd;
  dp_status_t         sts;
  logic [1:0]         out_state;
  logic [FIELD_W-1:0] out_field;

  // The register port never stalls. Only the word at addresses 0 to 3 exists;
  // addresses 4 to 7 ignore writes and read back zero.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else if (cfg_wr) begin
      delim_r <= cfg_pwdata[CHAR_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {{(32 - CHAR_W){1'b0}}, delim_r};

  assign in_req = req_t'(in_tuser);

  skm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_req   (in_req),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req            (in_req),
    .in_field_index    (in_tdata[2:0]),
    .in_char_pos       (in_tdata[6:3]),
    .in_char_value     (in_tdata[14:7]),
    .in_name_length    (in_tdata[19:15]),
    .delim             (delim_r),
    .out_ready         (out_tready),
    .out_valid         (out_tvalid),
    .out_match_state   (out_state),
    .out_matched_field (out_field)
  );

  assign out_tdata = {3'b000, out_field, out_state};

endmodule

`default_nettype wire

// ===== hdl/skm_ctrl.sv =====
// Controller state machine for the key name matcher.
// Depends on skm_pkg; drives skm_dp through command and status structs.
`default_nettype none

module skm_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire skm_pkg::req_t   in_req,
  output logic                 in_ready,
  input  wire skm_pkg::dp_status_t sts,
  output skm_pkg::ctrl_cmd_t   cmd
);
  import skm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req == REQ_KEY_CHAR && !sts.decided) begin
            state_nxt = ST_PRIME;
          end else begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_PRIME: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        priority if (sts.hit) begin
          state_nxt = ST_RESULT;
        end else if (sts.last) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.prime  = (state_r == ST_PRIME);
    cmd.scan   = (state_r == ST_SCAN);
    cmd.finish = (state_r == ST_FINISH);
    cmd.emit   = (state_r == ST_RESULT) && sts.out_free;
  end

endmodule

`default_nettype wire

// ===== hdl/skm_dp.sv =====
// Datapath of the key name matcher: name memory, lengths, field status,
// key cursor, outcome and the output register. Depends on skm_pkg.
`default_nettype none

module skm_dp (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire skm_pkg::ctrl_cmd_t    cmd,
  output skm_pkg::dp_status_t        sts,
  input  wire skm_pkg::req_t         in_req,
  input  wire [skm_pkg::FIELD_W-1:0] in_field_index,
  input  wire [skm_pkg::POS_W-1:0]   in_char_pos,
  input  wire [skm_pkg::CHAR_W-1:0]  in_char_value,
  input  wire [skm_pkg::LEN_W-1:0]   in_name_length,
  input  wire [skm_pkg::CHAR_W-1:0]  delim,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic [1:0]                 out_match_state,
  output logic [skm_pkg::FIELD_W-1:0] out_matched_field
);
  import skm_pkg::*;

  logic [CHAR_W-1:0]  name_mem [MEM_DEPTH];
  logic [CHAR_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0]  rd_addr;

  logic [LEN_W-1:0]   len_r [NUM_FIELDS];
  logic [NUM_FIELDS-1:0] live_r;
  logic [LEN_W-1:0]   cursor_r;
  outcome_t           outcome_r;
  logic [FIELD_W-1:0] winner_r;
  logic [FIELD_W-1:0] idx_r;
  logic [CHAR_W-1:0]  key_r;
  logic               any_live_r;

  logic               out_valid_r;
  logic [1:0]         out_state_r;
  logic [FIELD_W-1:0] out_field_r;

  logic               ended;
  logic               hit;
  logic [FIELD_W-1:0] idx_next;

  assign idx_next = idx_r + FIELD_W'(1);
  assign rd_addr  = cmd.prime ? {{FIELD_W{1'b0}}, cursor_r[POS_W-1:0]}
                              : {idx_next, cursor_r[POS_W-1:0]};

  // A field whose name has ended succeeds only on the delimiter.
  assign ended = (cursor_r >= len_r[idx_r]);
  assign hit   = cmd.scan && live_r[idx_r] && ended && (key_r == delim);

  always_comb begin
    sts.decided  = (outcome_r != OUT_MATCHING);
    sts.hit      = hit;
    sts.last     = (idx_r == LAST_FIELD);
    sts.out_free = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_req == REQ_WRITE_CHAR) begin
      name_mem[{in_field_index, in_char_pos}] <= in_char_value;
    end
    rd_data_r <= name_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r <= in_char_value;
    end
    if (cmd.prime) begin
      idx_r      <= '0;
      any_live_r <= 1'b0;
    end else if (cmd.scan) begin
      idx_r <= idx_next;
      if (live_r[idx_r] && !ended && rd_data_r == key_r) begin
        any_live_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        len_r[i] <= '0;
      end
      live_r      <= '1;
      cursor_r    <= '0;
      outcome_r   <= OUT_MATCHING;
      winner_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && in_req == REQ_SET_LEN) begin
        len_r[in_field_index] <= (in_name_length > LEN_MAX) ? LEN_MAX : in_name_length;
      end
      if (cmd.accept && in_req == REQ_BEGIN_KEY) begin
        live_r    <= '1;
        cursor_r  <= '0;
        outcome_r <= OUT_MATCHING;
        winner_r  <= '0;
      end
      if (cmd.scan && live_r[idx_r]) begin
        priority if (hit) begin
          live_r[idx_r] <= 1'b0;
          outcome_r     <= OUT_MATCHED;
          winner_r      <= idx_r;
        end else if (ended || rd_data_r != key_r) begin
          live_r[idx_r] <= 1'b0;
        end else begin
          // The name character agrees, so the field stays live.
          live_r[idx_r] <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (cursor_r < LEN_MAX) begin
          cursor_r <= cursor_r + LEN_W'(1);
        end
        if (!any_live_r) begin
          outcome_r <= OUT_ALLFAIL;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_state_r <= outcome_r;
      out_field_r <= (outcome_r == OUT_MATCHED) ? winner_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_match_state   = out_state_r;
  assign out_matched_field = out_field_r;

endmodule

`default_nettype wire
